/* rtl/pcg32_generator_splitmix_seeded_unit_assert.svh */
// Assertion macros shared by the RTL modules.
`ifndef PCG32_GENERATOR_SPLITMIX_SEEDED_UNIT_ASSERT_SVH
`define PCG32_GENERATOR_SPLITMIX_SEEDED_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PCG32_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define PCG32_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PCG32_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCG32_ASSERT(lbl, clk, rstn, expr)
`define PCG32_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PCG32_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/pcg32_pkg.sv */
`default_nettype none
package pcg32_pkg;

  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } mul_rsp_t;

  // XSH RR output permutation
  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [63:0] x;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] t;
    x   = old ^ (old >> 18);
    xs  = x[58:27];
    rot = old[63:59];
    t   = {xs, xs} >> rot;
    return t[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/pcg32_in_if.sv */
`default_nettype none
interface pcg32_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] entropy;

  modport source (output valid, output mode, output entropy, input ready);
  modport sink (input valid, input mode, input entropy, output ready);
endinterface
`default_nettype wire

/* rtl/pcg32_out_if.sv */
`default_nettype none
interface pcg32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface
`default_nettype wire

/* rtl/pcg32_mul64.sv */
`default_nettype none
`include "pcg32_generator_splitmix_seeded_unit_assert.svh"
// a * b + c mod 2^64 on one 32x32 multiplier, four passes.
module pcg32_mul64 (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pcg32_pkg::mul_req_t req_i,
  output pcg32_pkg::mul_rsp_t      rsp_o
);

  logic [63:0] a_q, b_q, c_q;
  logic [63:0] prod_q, acc_q;
  logic        busy_q, done_q;
  logic [1:0]  cnt_q;
  logic [31:0] ma, mb;
  logic [63:0] mul_p;

  always_comb begin
    ma = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    mb = (cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];
  end

  assign mul_p = {32'd0, ma} * {32'd0, mb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          a_q    <= req_i.a;
          b_q    <= req_i.b;
          c_q    <= req_i.c;
          busy_q <= 1'b1;
          cnt_q  <= 2'd0;
        end
      end else begin
        prod_q <= mul_p;
        cnt_q  <= cnt_q + 2'd1;
        case (cnt_q)
          2'd1:    acc_q <= prod_q + c_q;
          2'd2:    acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
          2'd3: begin
            acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
            done_q       <= 1'b1;
            busy_q       <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

  `PCG32_ASSERT(a_no_restart, clk_i, rst_ni, !(req_i.start && busy_q))
  `PCG32_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q)
  `PCG32_ASSERT_NEXT(a_finish, clk_i, rst_ni, busy_q && cnt_q == 2'd3, done_q && !busy_q)

endmodule
`default_nettype wire

/* rtl/pcg32_generator_splitmix_seeded_unit.sv */
`default_nettype none
`include "pcg32_generator_splitmix_seeded_unit_assert.svh"
// Channel  Dir  Fields                 Role
// req_i    in   mode, entropy          draw (mode 0) or reseed (mode 1)
// rsp_o    out  random_word            one word per draw
//
// A draw is one 64-bit LCG step on the shared 32x32 multiplier.
// A reseed runs 2 to 17 mixer rounds.
// Reset: state zero, increment one, no transaction pending.
// req_i.ready is high only while idle; a stalled rsp_o holds the next draw in its last step.
module pcg32_generator_splitmix_seeded_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcg32_in_if.sink  req_i,
  pcg32_out_if.source rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MIX_A, ST_MIX_WA, ST_MIX_WB, ST_DRAW_W, ST_DRAW_PUSH
  } state_e;

  state_e              state_q;
  logic [63:0]         gen_q, inc_q, v_q;
  logic [3:0]          rem_q;
  logic                inc_phase_q;
  logic [31:0]         word_q, out_word_q;
  logic                out_valid_q;
  logic                accept;
  logic                push;
  logic [63:0]         mix_pre, mix_mid, mix_fin;
  pcg32_pkg::mul_req_t mul_req;
  pcg32_pkg::mul_rsp_t mul_rsp;

  pcg32_mul64 u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign req_i.ready       = (state_q == ST_IDLE);
  assign accept            = req_i.valid && req_i.ready;
  assign push              = (state_q == ST_DRAW_PUSH) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.random_word = out_word_q;

  assign mix_pre = v_q ^ (v_q >> 30);
  assign mix_mid = mul_rsp.res ^ (mul_rsp.res >> 27);
  assign mix_fin = mul_rsp.res ^ (mul_rsp.res >> 31);

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = mix_pre;
    mul_req.b     = pcg32_pkg::MIX_MUL_A;
    mul_req.c     = 64'd0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !req_i.mode) begin
          mul_req.start = 1'b1;
          mul_req.a     = gen_q;
          mul_req.b     = pcg32_pkg::LCG_MUL;
          mul_req.c     = inc_q;
        end
      end
      ST_MIX_A: mul_req.start = 1'b1;
      ST_MIX_WA: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mix_mid;
          mul_req.b     = pcg32_pkg::MIX_MUL_B;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= 64'd0;
      inc_q       <= 64'd1;
      inc_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (push) begin
        out_word_q  <= word_q;
        out_valid_q <= 1'b1;
      end else if (rsp_o.valid && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (req_i.mode) begin
              v_q         <= req_i.entropy;
              rem_q       <= req_i.entropy[3:0] ^ req_i.entropy[20:17];
              inc_phase_q <= 1'b0;
              state_q     <= ST_MIX_A;
            end else begin
              word_q  <= pcg32_pkg::xsh_rr(gen_q);
              state_q <= ST_DRAW_W;
            end
          end
        end
        ST_MIX_A: state_q <= ST_MIX_WA;
        ST_MIX_WA: begin
          if (mul_rsp.done) begin
            state_q <= ST_MIX_WB;
          end
        end
        ST_MIX_WB: begin
          if (mul_rsp.done) begin
            if (inc_phase_q) begin
              inc_q   <= mix_fin | 64'd1;
              state_q <= ST_IDLE;
            end else begin
              v_q     <= mix_fin;
              state_q <= ST_MIX_A;
              if (rem_q == 4'd0) begin
                gen_q       <= mix_fin;
                inc_phase_q <= 1'b1;
              end else begin
                rem_q <= rem_q - 4'd1;
              end
            end
          end
        end
        ST_DRAW_W: begin
          if (mul_rsp.done) begin
            gen_q   <= mul_rsp.res;
            state_q <= ST_DRAW_PUSH;
          end
        end
        ST_DRAW_PUSH: begin
          if (push) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `PCG32_ASSERT(a_inc_odd, clk_i, rst_ni, inc_q[0])
  `PCG32_ASSERT_IMPL(a_done_waiting, clk_i, rst_ni, mul_rsp.done,
    state_q == ST_MIX_WA || state_q == ST_MIX_WB || state_q == ST_DRAW_W)
  `PCG32_ASSERT_NEXT(a_push_idle, clk_i, rst_ni, push, out_valid_q && state_q == ST_IDLE)

endmodule
`default_nettype wire
